// File: sv/route_table_best_next_hop_core_defines.svh
// Assertion macros shared by the route table core.
`ifndef ROUTE_TABLE_BEST_NEXT_HOP_CORE_DEFINES_SVH
`define ROUTE_TABLE_BEST_NEXT_HOP_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTBNH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("route table check failed");

// The consequent must hold in the cycle after the antecedent.
`define RTBNH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("route table check failed");

`endif

// File: sv/rtbnh_pkg.sv
// Types, codes and helper functions of the route table core.
package rtbnh_pkg;

    localparam int USED_W    = 6;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_UPDATE = 2'd1,
        OP_RENEW  = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_MISS = 2'd2
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIFESPAN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKUP_POLICY = 2'd1;

    localparam logic [7:0] MAX_LIFESPAN_RST  = 8'd10;
    localparam logic       LOOKUP_POLICY_RST = 1'b1;

    localparam logic POLICY_FIRST = 1'b0;

    // One route entry as held in the table memory. Quality is two's complement.
    typedef struct packed {
        logic [7:0] dest;
        logic [7:0] via_node;
        logic [7:0] seq_num;
        logic [7:0] hops;
        logic [7:0] quality;
        logic [7:0] life;
    } entry_t;

    // Halves a 9-bit two's complement value, rounding toward zero.
    function automatic logic [7:0] half_to_zero(input logic [8:0] v);
        logic [8:0] adj;
        adj = v + {8'd0, v[8]};
        return adj[8:1];
    endfunction

endpackage

// File: sv/rtbnh_ram.sv
// Route entry memory: one write port, one read port with registered data.
module rtbnh_ram
    import rtbnh_pkg::*;
#(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/route_table_best_next_hop_core.sv
// Top level of the route table: command port, configuration port and scan sequencer.
//
// Channel    Direction  Handshake                     Word
// command    in         start && !busy               op, dest, via_node, seq_num, hops, snr
// result     out        done (one cycle, no stall)    hop_out, status, entries_used
// config     in         cfg_valid && cfg_ready        cfg_index, cfg_data
//
// An add, or any command on an empty table, gives its result the cycle after it is taken.
// Update, renew and lookup read the table memory one entry per cycle through its single
// read port; a match or a first-match lookup ends the scan early. One command is in
// flight at a time; busy is high while it runs.
// Reset clears the entry count and loads the register defaults; the memory is not cleared.
// The result receiver cannot stall: each result is shown for exactly one cycle.
`include "route_table_best_next_hop_core_defines.svh"

module route_table_best_next_hop_core
    import rtbnh_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           op,
    input  logic [7:0]           dest,
    input  logic [7:0]           via_node,
    input  logic [7:0]           seq_num,
    input  logic [7:0]           hops,
    input  logic signed [7:0]    snr,
    output logic                 done,
    output logic [7:0]           hop_out,
    output logic [1:0]           status,
    output logic [USED_W-1:0]    entries_used,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic [IDX_W-1:0]  didx_reg, didx_next;
    logic              issue_reg, issue_next;
    logic              vld_reg, vld_next;
    logic              found_reg, found_next;
    logic              done_reg, done_next;
    logic [7:0]        hop_out_reg, hop_out_next;
    status_t           status_reg, status_next;
    logic [USED_W-1:0] used_reg, used_next;

    logic [1:0]        op_reg, op_next;
    logic [7:0]        dest_reg, dest_next;
    logic [7:0]        nh_reg, nh_next;
    logic [7:0]        seq_reg, seq_next;
    logic [7:0]        hops_reg, hops_next;
    logic [7:0]        snr_reg, snr_next;
    logic [7:0]        best_hop_reg, best_hop_next;
    logic [7:0]        best_q_reg, best_q_next;
    logic [7:0]        best_d_reg, best_d_next;

    logic [7:0]        max_life_reg;
    logic              policy_reg;

    logic              accept;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    entry_t            rd_entry;
    logic [IDX_W-1:0]  last_idx;
    logic              is_last;
    logic              hit_dest;
    logic              hit_both;
    logic              better;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_life_reg <= MAX_LIFESPAN_RST;
            policy_reg   <= LOOKUP_POLICY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_LIFESPAN:  max_life_reg <= cfg_data;
                CFG_LOOKUP_POLICY: policy_reg   <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    rtbnh_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_entry)
    );

    assign last_idx = IDX_W'(count_reg - 1'b1);
    assign is_last  = (didx_reg == last_idx);
    assign hit_dest = (rd_entry.dest == dest_reg);
    assign hit_both = hit_dest && (rd_entry.seq_num == seq_reg);
    // Higher quality wins; equal quality falls to fewer hops; otherwise the earlier entry stays.
    assign better   = hit_dest && (!found_reg
                      || ($signed(rd_entry.quality) > $signed(best_q_reg))
                      || ((rd_entry.quality == best_q_reg) && (rd_entry.hops < best_d_reg)));

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        addr_next     = addr_reg;
        didx_next     = didx_reg;
        issue_next    = issue_reg;
        vld_next      = vld_reg;
        found_next    = found_reg;
        done_next     = 1'b0;
        hop_out_next  = hop_out_reg;
        status_next   = status_reg;
        op_next       = op_reg;
        dest_next     = dest_reg;
        nh_next       = nh_reg;
        seq_next      = seq_reg;
        hops_next     = hops_reg;
        snr_next      = snr_reg;
        best_hop_next = best_hop_reg;
        best_q_next   = best_q_reg;
        best_d_next   = best_d_reg;
        wr_en         = 1'b0;
        wr_addr       = didx_reg;
        wr_data       = rd_entry;
        rd_en         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = op;
                    dest_next = dest;
                    nh_next   = via_node;
                    seq_next  = seq_num;
                    hops_next = hops;
                    snr_next  = snr;
                    if (op == OP_ADD)
                    begin
                        done_next    = 1'b1;
                        hop_out_next = 8'd0;
                        if (count_reg < CNT_W'(TABLE_DEPTH))
                        begin
                            wr_en            = 1'b1;
                            wr_addr          = count_reg[IDX_W-1:0];
                            wr_data.dest     = dest;
                            wr_data.via_node = via_node;
                            wr_data.seq_num  = seq_num;
                            wr_data.hops     = hops;
                            wr_data.quality  = half_to_zero({snr[7], snr});
                            wr_data.life     = 8'd0;
                            count_next       = count_reg + 1'b1;
                            status_next      = STATUS_OK;
                        end
                        else
                        begin
                            status_next = STATUS_FULL;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next    = 1'b1;
                        hop_out_next = 8'd0;
                        status_next  = STATUS_MISS;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                        addr_next  = '0;
                        issue_next = 1'b1;
                        vld_next   = 1'b0;
                        found_next = 1'b0;
                    end
                end
            end

            ST_SCAN:
            begin
                // Reads run one entry ahead of the compare; the read data lands in the next cycle.
                rd_en     = issue_reg;
                vld_next  = issue_reg;
                didx_next = addr_reg;
                if (issue_reg)
                begin
                    if (addr_reg == last_idx)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        addr_next = addr_reg + 1'b1;
                    end
                end

                if (vld_reg)
                begin
                    if ((op_reg == OP_UPDATE) || (op_reg == OP_RENEW))
                    begin
                        if (hit_both)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = didx_reg;
                            if (op_reg == OP_UPDATE)
                            begin
                                wr_data.via_node = nh_reg;
                                wr_data.hops     = hops_reg;
                                wr_data.quality  = half_to_zero(
                                    {rd_entry.quality[7], rd_entry.quality}
                                    + {snr_reg[7], snr_reg});
                            end
                            else
                            begin
                                wr_data.life = max_life_reg;
                            end
                            state_next   = ST_IDLE;
                            done_next    = 1'b1;
                            hop_out_next = 8'd0;
                            status_next  = STATUS_OK;
                        end
                        else if (is_last)
                        begin
                            state_next   = ST_IDLE;
                            done_next    = 1'b1;
                            hop_out_next = 8'd0;
                            status_next  = STATUS_MISS;
                        end
                    end
                    else if (policy_reg == POLICY_FIRST)
                    begin
                        if (hit_dest)
                        begin
                            state_next   = ST_IDLE;
                            done_next    = 1'b1;
                            hop_out_next = rd_entry.via_node;
                            status_next  = STATUS_OK;
                        end
                        else if (is_last)
                        begin
                            state_next   = ST_IDLE;
                            done_next    = 1'b1;
                            hop_out_next = 8'd0;
                            status_next  = STATUS_MISS;
                        end
                    end
                    else
                    begin
                        if (better)
                        begin
                            found_next    = 1'b1;
                            best_hop_next = rd_entry.via_node;
                            best_q_next   = rd_entry.quality;
                            best_d_next   = rd_entry.hops;
                        end
                        if (is_last)
                        begin
                            state_next  = ST_IDLE;
                            done_next   = 1'b1;
                            if (found_reg || hit_dest)
                            begin
                                hop_out_next = better ? rd_entry.via_node : best_hop_reg;
                                status_next  = STATUS_OK;
                            end
                            else
                            begin
                                hop_out_next = 8'd0;
                                status_next  = STATUS_MISS;
                            end
                        end
                    end
                end

                if (state_next == ST_IDLE)
                begin
                    issue_next = 1'b0;
                    vld_next   = 1'b0;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
                issue_next = 1'b0;
                vld_next   = 1'b0;
            end
        endcase

        used_next = USED_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            addr_reg    <= '0;
            didx_reg    <= '0;
            issue_reg   <= 1'b0;
            vld_reg     <= 1'b0;
            found_reg   <= 1'b0;
            done_reg    <= 1'b0;
            hop_out_reg <= 8'd0;
            status_reg  <= STATUS_OK;
            used_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            addr_reg    <= addr_next;
            didx_reg    <= didx_next;
            issue_reg   <= issue_next;
            vld_reg     <= vld_next;
            found_reg   <= found_next;
            done_reg    <= done_next;
            hop_out_reg <= hop_out_next;
            status_reg  <= status_next;
            used_reg    <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        dest_reg     <= dest_next;
        nh_reg       <= nh_next;
        seq_reg      <= seq_next;
        hops_reg     <= hops_next;
        snr_reg      <= snr_next;
        best_hop_reg <= best_hop_next;
        best_q_reg   <= best_q_next;
        best_d_reg   <= best_d_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign hop_out      = hop_out_reg;
    assign status       = status_reg;
    assign entries_used = used_reg;

    `RTBNH_ASSERT_IMP(a_done_when_idle, clk, rst_n, done, !busy)
    `RTBNH_ASSERT_NEXT(a_accept_progress, clk, rst_n, accept, busy || done)
    `RTBNH_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH))
    `RTBNH_ASSERT_IMP(a_write_in_command, clk, rst_n, wr_en, busy || accept)

endmodule
